>>> rtl/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Every macro samples on the rising edge of aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define AST_HOLDS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define AST_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/stl_pkg.sv
// Package for the script token lexer: token categories, character classes,
// the keyword table and the result types shared by all lexer modules. No dependencies.
package stl_pkg;

    localparam int POS_BITS_DEFAULT     = 16;
    localparam int PREFIX_CHARS_DEFAULT = 8;
    localparam int POS_W_LIMIT          = 32;
    localparam int OUTQ_DEPTH           = 4;
    localparam int RESULTS_MAX          = 3;
    localparam int IN_TDATA_W           = 8;
    localparam int OUT_TDATA_W          = 40;
    localparam int KW_COUNT             = 13;
    localparam int KW_MAX_CHARS         = 8;

    localparam logic [3:0] CAT_IDENT   = 4'd0;
    localparam logic [3:0] CAT_KEYWORD = 4'd1;
    localparam logic [3:0] CAT_BOOL    = 4'd2;
    localparam logic [3:0] CAT_INT     = 4'd3;
    localparam logic [3:0] CAT_FLOAT   = 4'd4;
    localparam logic [3:0] CAT_OP      = 4'd5;
    localparam logic [3:0] CAT_PUNCT   = 4'd6;
    localparam logic [3:0] CAT_STRING  = 4'd7;
    localparam logic [3:0] CAT_ERROR   = 4'd8;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Keyword texts are right-aligned, so the first character sits in the highest used byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "let", "var", "const", "function", "return", "if", "else",
        "for", "while", "break", "continue", "true", "false"
    };
    localparam int KW_LEN [KW_COUNT] = '{3, 3, 5, 8, 6, 2, 4, 3, 5, 5, 8, 4, 5};
    localparam logic [3:0] KW_CAT [KW_COUNT] = '{
        CAT_KEYWORD, CAT_KEYWORD, CAT_KEYWORD, CAT_KEYWORD, CAT_KEYWORD,
        CAT_KEYWORD, CAT_KEYWORD, CAT_KEYWORD, CAT_KEYWORD, CAT_KEYWORD,
        CAT_KEYWORD, CAT_BOOL, CAT_BOOL
    };

    typedef struct packed {
        logic [3:0]  cat;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0]       count;
        res_t [RESULTS_MAX-1:0] item;
    } res_bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return c inside {8'h3D, 8'h21, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3C, 8'h3E};
    endfunction

    function automatic logic is_punct_char(input logic [7:0] c);
        return c inside {8'h3B, 8'h2E, 8'h2C, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D};
    endfunction

    // Classifies a finished name from its first characters (first character in the
    // lowest byte) and its length.
    function automatic logic [3:0] word_category(input logic [63:0] chars,
                                                 input logic [15:0] len);
        logic [3:0] cat;
        logic       hit;
        cat = CAT_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_CHARS; i++) begin
                if (i < KW_LEN[k]) begin
                    hit = hit && (chars[8*i +: 8] == KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]);
                end
            end
            if (hit) begin
                cat = KW_CAT[k];
            end
        end
        return cat;
    endfunction

endpackage

>>> rtl/stl_core.sv
// Lexer state machine: classifies one byte per transaction and produces up to three tokens.
// Depends on stl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stl_core import stl_pkg::*; #(
    parameter int POSITION_BITS     = POS_BITS_DEFAULT,
    parameter int NAME_PREFIX_CHARS = PREFIX_CHARS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  char_code,
    input  logic        end_of_source,
    output res_bundle_t bundle
);

    localparam int IDX_W = $clog2(NAME_PREFIX_CHARS);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [7:0] {
        MODE_IDLE   = 8'b0000_0001,
        MODE_IDENT  = 8'b0000_0010,
        MODE_INT    = 8'b0000_0100,
        MODE_INTDOT = 8'b0000_1000,
        MODE_FLOAT  = 8'b0001_0000,
        MODE_OP     = 8'b0010_0000,
        MODE_STRING = 8'b0100_0000,
        MODE_ERROR  = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic v0;
        res_t r0;
        logic v1;
        res_t r1;
    } flush_t;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [15:0]              plen_reg, plen_next;
    logic [POSITION_BITS-1:0] dot_reg, dot_next;
    logic [7:0]               prefix_reg [NAME_PREFIX_CHARS];
    logic [7:0]               prefix_next [NAME_PREFIX_CHARS];

    logic [POSITION_BITS-1:0] pos_inc;
    logic [63:0]              chars_now, chars_mid;
    logic [3:0]               icat_now, icat_mid;
    res_t [4:0]               cand;
    logic [4:0]               cand_v;
    flush_t                   fa, fc;
    logic                     taken;
    mode_t                    mode_mid;
    logic [POSITION_BITS-1:0] pstart_mid, dot_mid;
    logic [15:0]              plen_mid;
    res_t [RESULTS_MAX-1:0]   outs;
    logic [1:0]               n;
    logic                     at_start;
    logic                     in_error;

    function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
        logic [POS_W_LIMIT-1:0] w;
        w = POS_W_LIMIT'(v);
        return (|w[POS_W_LIMIT-1:16]) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [15:0] add_len(input logic [15:0] l, input logic [1:0] d);
        logic [16:0] s;
        s = 17'(l) + 17'(d);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic flush_t flush_of(input mode_t m, input logic [POSITION_BITS-1:0] st,
                                        input logic [15:0] ln,
                                        input logic [POSITION_BITS-1:0] dot,
                                        input logic [3:0] icat);
        flush_t f;
        f = '0;
        case (m)
            MODE_IDENT: begin
                f.v0 = 1'b1;
                f.r0 = '{cat: icat, start: sat16(st), length: ln, last: 1'b0};
            end
            MODE_INT: begin
                f.v0 = 1'b1;
                f.r0 = '{cat: CAT_INT, start: sat16(st), length: ln, last: 1'b0};
            end
            MODE_INTDOT: begin
                f.v0 = 1'b1;
                f.r0 = '{cat: CAT_INT, start: sat16(st), length: ln, last: 1'b0};
                f.v1 = 1'b1;
                f.r1 = '{cat: CAT_PUNCT, start: sat16(dot), length: 16'd1, last: 1'b0};
            end
            MODE_FLOAT: begin
                f.v0 = 1'b1;
                f.r0 = '{cat: CAT_FLOAT, start: sat16(st), length: ln, last: 1'b0};
            end
            MODE_OP: begin
                f.v0 = 1'b1;
                f.r0 = '{cat: CAT_OP, start: sat16(st), length: 16'd1, last: 1'b0};
            end
            MODE_STRING: begin
                f.v0 = 1'b1;
                f.r0 = '{cat: CAT_STRING, start: sat16(st), length: ln, last: 1'b0};
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb begin
        for (int i = 0; i < KW_MAX_CHARS; i++) begin
            chars_now[8*i +: 8] = prefix_reg[i];
        end
        icat_now = word_category(chars_now, plen_reg);
        fa       = flush_of(mode_reg, pstart_reg, plen_reg, dot_reg, icat_now);
    end

    always_comb begin
        cand        = '0;
        cand_v      = '0;
        taken       = 1'b0;
        mode_mid    = mode_reg;
        pstart_mid  = pstart_reg;
        plen_mid    = plen_reg;
        dot_mid     = dot_reg;
        prefix_next = prefix_reg;

        // The byte first continues or ends the pending token.
        case (mode_reg)
            MODE_ERROR: begin
                taken = 1'b1;
            end
            MODE_IDENT: begin
                if (is_letter(char_code) || is_digit(char_code)) begin
                    if (plen_reg < 16'(NAME_PREFIX_CHARS)) begin
                        prefix_next[plen_reg[IDX_W-1:0]] = char_code;
                    end
                    plen_mid = add_len(plen_reg, 2'd1);
                    taken    = 1'b1;
                end else begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_INT: begin
                if (is_digit(char_code)) begin
                    plen_mid = add_len(plen_reg, 2'd1);
                    taken    = 1'b1;
                end else if (char_code == CH_DOT) begin
                    dot_mid  = pos_reg;
                    mode_mid = MODE_INTDOT;
                    taken    = 1'b1;
                end else begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_INTDOT: begin
                if (is_digit(char_code)) begin
                    plen_mid = add_len(plen_reg, 2'd2);
                    mode_mid = MODE_FLOAT;
                    taken    = 1'b1;
                end else begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_FLOAT: begin
                if (is_digit(char_code)) begin
                    plen_mid = add_len(plen_reg, 2'd1);
                    taken    = 1'b1;
                end else begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_OP: begin
                if (char_code == CH_EQ) begin
                    cand[0]   = '{cat: CAT_OP, start: sat16(pstart_reg), length: 16'd2,
                                  last: 1'b0};
                    cand_v[0] = 1'b1;
                    taken     = 1'b1;
                end
                mode_mid = MODE_IDLE;
            end
            MODE_STRING: begin
                if (char_code == CH_QUOTE) begin
                    mode_mid = MODE_IDLE;
                end else begin
                    plen_mid = add_len(plen_reg, 2'd1);
                end
                taken = 1'b1;
            end
            default: begin
                mode_mid = MODE_IDLE;
            end
        endcase

        if (mode_reg != MODE_OP && mode_reg != MODE_ERROR && mode_mid == MODE_IDLE) begin
            cand[0]   = fa.r0;
            cand_v[0] = fa.v0;
            cand[1]   = fa.r1;
            cand_v[1] = fa.v1;
        end else if (mode_reg == MODE_OP && !taken) begin
            cand[0]   = fa.r0;
            cand_v[0] = fa.v0;
        end

        // A byte not absorbed by the pending token starts a new one, unless it is white space.
        if (!taken) begin
            if (is_space(char_code)) begin
                mode_mid = MODE_IDLE;
            end else if (is_letter(char_code)) begin
                for (int i = 0; i < NAME_PREFIX_CHARS; i++) begin
                    prefix_next[i] = 8'h00;
                end
                prefix_next[0] = char_code;
                pstart_mid     = pos_reg;
                plen_mid       = 16'd1;
                mode_mid       = MODE_IDENT;
            end else if (is_digit(char_code)) begin
                pstart_mid = pos_reg;
                plen_mid   = 16'd1;
                mode_mid   = MODE_INT;
            end else if (is_op_char(char_code)) begin
                pstart_mid = pos_reg;
                plen_mid   = 16'd1;
                mode_mid   = MODE_OP;
            end else if (is_punct_char(char_code)) begin
                cand[2]   = '{cat: CAT_PUNCT, start: sat16(pos_reg), length: 16'd1,
                              last: 1'b0};
                cand_v[2] = 1'b1;
            end else if (char_code == CH_QUOTE) begin
                pstart_mid = pos_inc;
                plen_mid   = 16'd0;
                mode_mid   = MODE_STRING;
            end else begin
                cand[2]   = '{cat: CAT_ERROR, start: sat16(pos_reg), length: 16'd1,
                              last: 1'b0};
                cand_v[2] = 1'b1;
                mode_mid  = MODE_ERROR;
            end
        end

        for (int i = 0; i < KW_MAX_CHARS; i++) begin
            chars_mid[8*i +: 8] = prefix_next[i];
        end
        icat_mid = word_category(chars_mid, plen_mid);
        fc       = flush_of(mode_mid, pstart_mid, plen_mid, dot_mid, icat_mid);
        if (end_of_source) begin
            cand[3]   = fc.r0;
            cand_v[3] = fc.v0;
            cand[4]   = fc.r1;
            cand_v[4] = fc.v1;
        end

        // Pack the candidates in order, at most three per byte.
        outs = '0;
        n    = 2'd0;
        for (int i = 0; i < 5; i++) begin
            if (cand_v[i] && n != 2'd3) begin
                outs[n] = cand[i];
                n       = n + 2'd1;
            end
        end
        for (int j = 0; j < RESULTS_MAX; j++) begin
            outs[j].last = (n == 2'(j + 1));
        end

        if (end_of_source) begin
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end else begin
            mode_next = mode_mid;
            pos_next  = pos_inc;
        end
        pstart_next = pstart_mid;
        plen_next   = plen_mid;
        dot_next    = dot_mid;
    end

    assign bundle = '{count: (in_fire ? n : 2'd0), item: outs};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            dot_reg    <= dot_next;
            for (int i = 0; i < NAME_PREFIX_CHARS; i++) begin
                prefix_reg[i] <= prefix_next[i];
            end
        end
    end

    assign at_start = (mode_reg == MODE_IDLE) && (pos_reg == '0);
    assign in_error = (mode_reg == MODE_ERROR);

    `AST_NEXT(a_eos_restarts, in_fire && end_of_source, at_start, "Source end left state behind.")
    `AST_IMPLIES(a_error_silent, in_fire && in_error, bundle.count == 2'd0, "Token after bad byte.")
    `AST_HOLDS(a_mode_onehot, $onehot(mode_reg), "Lexer mode is not one-hot.")

endmodule

>>> rtl/stl_outq.sv
// Output queue of the lexer: takes up to three tokens per cycle and hands out one per transaction.
// Depends on stl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stl_outq import stl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  res_bundle_t push,
    output logic        has_room,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_item
);

    localparam int DEPTH = OUTQ_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic          stall;

    assign m_valid  = (count_reg != '0);
    assign m_item   = mem_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;
    assign stall    = m_valid && !m_ready;
    assign has_room = (count_reg <= CW'(DEPTH - RESULTS_MAX));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < RESULTS_MAX; k++) begin
            if (2'(k) < push.count) begin
                mem_reg[wr_ptr_reg + AW'(k)] <= push.item[k];
            end
        end
    end

    `AST_HOLDS(a_count_bound, count_reg <= CW'(DEPTH), "Output queue overflowed.")
    `AST_IMPLIES(a_push_room, push.count != 2'd0, has_room, "Tokens pushed without room.")
    `AST_NEXT(a_head_stable, stall, m_valid && $stable(m_item), "Head changed while stalled.")

endmodule

>>> rtl/script_token_lexer.sv
// Streaming lexer for a small scripting language: one source byte in per transaction,
// tokens out as category, start offset and length. Top level; uses stl_pkg, stl_core, stl_outq.
//
// A byte is taken in every cycle as long as each byte completes at most one token and m_tready
// is high; a token appears on the output in the cycle after the byte that completes it. A byte
// that completes two or three tokens holds the output for that many transactions, and the input
// waits because the four-entry output queue admits a byte only while it has room for three
// tokens. The last token caused by a byte carries m_tlast. A byte with s_tlast high ends the
// source, flushes the pending token and restarts offsets at zero for the next source.

module script_token_lexer import stl_pkg::*; #(
    parameter int POSITION_BITS     = POS_BITS_DEFAULT,
    parameter int NAME_PREFIX_CHARS = PREFIX_CHARS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                   s_tlast,   // end_of_source
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [3:0] category, [19:4] token_start,
                                              // [35:20] token_length, [39:36] zero
    output logic                   m_tlast    // last_in_run
);

    res_bundle_t bundle;
    res_t        item;
    logic        in_fire;
    logic        has_room;

    assign s_tready = has_room;
    assign in_fire  = s_tvalid && has_room;

    stl_core #(
        .POSITION_BITS    (POSITION_BITS),
        .NAME_PREFIX_CHARS(NAME_PREFIX_CHARS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .char_code    (s_tdata[7:0]),
        .end_of_source(s_tlast),
        .bundle       (bundle)
    );

    stl_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (bundle),
        .has_room(has_room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (item)
    );

    assign m_tdata = {4'b0000, item.length, item.start, item.cat};
    assign m_tlast = item.last;

endmodule
